[hdl/id3p_pkg.sv]
// Package for the ID3v2.3 tag frame parser: stage, error and frame kind codes,
// parse state and result records, frame ID constants and small helper functions.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package id3p_pkg;

  // parse stage, also driven out as the stage field
  typedef enum logic [2:0] {
    STAGE_TAG_HDR = 3'd0,
    STAGE_FRM_HDR = 3'd1,
    STAGE_PAYLOAD = 3'd2,
    STAGE_PAST    = 3'd3,
    STAGE_ERROR   = 3'd4
  } stage_e;

  // latched error code
  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_NO_MARKER = 2'd1,
    ERR_BAD_VALUE = 2'd2,
    ERR_FLAGS     = 2'd3
  } err_e;

  // frame classification
  typedef enum logic [2:0] {
    KIND_OTHER = 3'd0,
    KIND_COMM  = 3'd1,
    KIND_TALB  = 3'd2,
    KIND_TPE1  = 3'd3,
    KIND_TIT2  = 3'd4,
    KIND_TRCK  = 3'd5,
    KIND_TYER  = 3'd6,
    KIND_APIC  = 3'd7
  } kind_e;

  // known frame IDs, big-endian ASCII
  localparam logic [31:0] ID_COMM = 32'h434F_4D4D;
  localparam logic [31:0] ID_TALB = 32'h5441_4C42;
  localparam logic [31:0] ID_TPE1 = 32'h5450_4531;
  localparam logic [31:0] ID_TIT2 = 32'h5449_5432;
  localparam logic [31:0] ID_TRCK = 32'h5452_434B;
  localparam logic [31:0] ID_TYER = 32'h5459_4552;
  localparam logic [31:0] ID_APIC = 32'h4150_4943;

  // tag header layout
  localparam logic [7:0] TAG_MARKER [3] = '{8'h49, 8'h44, 8'h33};
  localparam logic [7:0] TAG_VER_MAJOR  = 8'h03;
  localparam logic [7:0] TAG_VER_MINOR  = 8'h00;
  localparam logic [7:0] TAG_FLAG_MASK  = 8'h40 | 8'h20 | 8'h1F;
  localparam logic [3:0] POS_VER_MAJOR  = 4'd3;
  localparam logic [3:0] POS_VER_MINOR  = 4'd4;
  localparam logic [3:0] POS_FLAGS      = 4'd5;
  localparam logic [3:0] POS_HDR_LAST   = 4'd9;

  // frame header layout
  localparam logic [3:0] POS_ID_LAST    = 4'd3;
  localparam logic [3:0] POS_SIZE_LAST  = 4'd7;
  localparam logic [3:0] POS_FLAG0      = 4'd8;

  localparam int TAG_SIZE_W = 28;

  typedef struct packed {
    stage_e                  stage;
    logic [3:0]              pos;
    logic [TAG_SIZE_W-1:0]   tag_left;
    logic [31:0]             id_shift;
    logic [31:0]             size_val;
    logic [31:0]             frame_left;
    kind_e                   kind;
    err_e                    err;
  } parse_state_t;

  typedef struct packed {
    stage_e      stage;
    err_e        err;
    kind_e       kind;
    logic [31:0] length;
    logic [7:0]  payload;
    logic        valid;
    logic        last;
    logic        done;
  } result_t;

  localparam parse_state_t PARSE_CLEAR = '{
    stage:      STAGE_TAG_HDR,
    pos:        4'd0,
    tag_left:   '0,
    id_shift:   32'd0,
    size_val:   32'd0,
    frame_left: 32'd0,
    kind:       KIND_OTHER,
    err:        ERR_NONE
  };

  // ASCII digit or letter of either case
  function automatic logic is_id_char(input logic [7:0] c);
    logic r;
    r = ((c >= 8'h30) && (c <= 8'h39)) ||
        ((c >= 8'h41) && (c <= 8'h5A)) ||
        ((c >= 8'h61) && (c <= 8'h7A));
    return r;
  endfunction

  // frame ID to kind
  function automatic kind_e kind_of(input logic [31:0] id);
    kind_e k;
    unique case (id)
      ID_COMM: k = KIND_COMM;
      ID_TALB: k = KIND_TALB;
      ID_TPE1: k = KIND_TPE1;
      ID_TIT2: k = KIND_TIT2;
      ID_TRCK: k = KIND_TRCK;
      ID_TYER: k = KIND_TYER;
      ID_APIC: k = KIND_APIC;
      default: k = KIND_OTHER;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

[hdl/id3v23_tag_frame_parser.sv]
// Top level of the ID3v2.3 tag frame parser: input register, parse state,
// result register and handshakes. Depends on id3p_pkg and id3p_step.
//
// Usage: file bytes enter one per beat on the input channel (in_valid_i /
// in_ready_o), with file_start_i high on the first byte of each file. Every
// input beat yields exactly one result beat on the output channel
// (out_valid_o / out_ready_i) with stage, error, frame kind and length, an
// optional payload byte and the frame_last and tag_done flags.
// A byte taken is held in the input register, parsed combinationally by the
// parse step and captured in the result register that drives the outputs.
// Throughput is one byte per clock while the receiver does not stall.
// Reset (rst_ni low, asynchronous) empties both registers, returns the parser
// to the tag header stage and clears emit_unknown_payload. The user must raise
// cfg_we_i to write emit_unknown_payload from cfg_wdata_i only while the block
// is idle; the block itself does not enforce this.
// When the receiver stalls, the result holds, the held input byte waits, and
// in_ready_o drops once both registers are full; nothing is lost or repeated.
`default_nettype none

module id3v23_tag_frame_parser import id3p_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_wdata_i,
  input  wire logic        in_valid_i,
  output      logic        in_ready_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        file_start_i,
  output      logic        out_valid_o,
  input  wire logic        out_ready_i,
  output      logic [2:0]  stage_o,
  output      logic [1:0]  error_code_o,
  output      logic [2:0]  frame_kind_o,
  output      logic [31:0] frame_length_o,
  output      logic [7:0]  payload_byte_o,
  output      logic        payload_valid_o,
  output      logic        frame_last_o,
  output      logic        tag_done_o
);

  logic         emit_q;
  logic         in_valid_q;
  logic [7:0]   in_byte_q;
  logic         in_start_q;
  parse_state_t state_q;
  parse_state_t state_d;
  logic         out_valid_q;
  result_t      res_q;
  result_t      res_d;
  logic         out_free;
  logic         advance;

  // handshake flow
  assign out_free   = !out_valid_q || out_ready_i;
  assign advance    = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || advance;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emit_q <= 1'b0;
    end else if (cfg_we_i) begin
      emit_q <= cfg_wdata_i;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q  <= data_byte_i;
      in_start_q <= file_start_i;
    end
  end

  // parse step
  id3p_step u_step (
    .state_i        (state_q),
    .data_byte_i    (in_byte_q),
    .file_start_i   (in_start_q),
    .emit_unknown_i (emit_q),
    .state_o        (state_d),
    .result_o       (res_d)
  );

  // parse state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= PARSE_CLEAR;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  // outputs
  assign out_valid_o     = out_valid_q;
  assign stage_o         = res_q.stage;
  assign error_code_o    = res_q.err;
  assign frame_kind_o    = res_q.kind;
  assign frame_length_o  = res_q.length;
  assign payload_byte_o  = res_q.payload;
  assign payload_valid_o = res_q.valid;
  assign frame_last_o    = res_q.last;
  assign tag_done_o      = res_q.done;

endmodule

`default_nettype wire

[hdl/id3p_step.sv]
// Next-state and result logic for one byte of the ID3v2.3 parser.
// Purely combinational; depends on id3p_pkg.
`default_nettype none

module id3p_step import id3p_pkg::*; (
  input  parse_state_t state_i,
  input  logic [7:0]   data_byte_i,
  input  logic         file_start_i,
  input  logic         emit_unknown_i,
  output parse_state_t state_o,
  output result_t      result_o
);

  parse_state_t          cur;
  parse_state_t          nxt;
  result_t               res;
  err_e                  err;
  logic [TAG_SIZE_W-1:0] tag_dec;
  logic [31:0]           frame_dec;
  logic [TAG_SIZE_W-1:0] tag_shifted;

  // restart on a new file
  assign cur         = file_start_i ? PARSE_CLEAR : state_i;
  assign tag_dec     = cur.tag_left - TAG_SIZE_W'(1);
  assign frame_dec   = cur.frame_left - 32'd1;
  assign tag_shifted = {cur.tag_left[TAG_SIZE_W-8:0], data_byte_i[6:0]};

  always_comb begin
    nxt         = cur;
    err         = ERR_NONE;
    res.stage   = STAGE_TAG_HDR;
    res.err     = ERR_NONE;
    res.kind    = KIND_OTHER;
    res.length  = 32'd0;
    res.payload = 8'd0;
    res.valid   = 1'b0;
    res.last    = 1'b0;
    res.done    = 1'b0;

    unique case (cur.stage)
      // ten-byte tag header
      STAGE_TAG_HDR: begin
        if (cur.pos < POS_VER_MAJOR) begin
          if (data_byte_i != TAG_MARKER[cur.pos[1:0]]) err = ERR_NO_MARKER;
        end else if (cur.pos == POS_VER_MAJOR) begin
          if (data_byte_i != TAG_VER_MAJOR) err = ERR_BAD_VALUE;
        end else if (cur.pos == POS_VER_MINOR) begin
          if (data_byte_i != TAG_VER_MINOR) err = ERR_BAD_VALUE;
        end else if (cur.pos == POS_FLAGS) begin
          if ((data_byte_i & TAG_FLAG_MASK) != 8'd0) err = ERR_FLAGS;
        end else begin
          // syncsafe size byte, msb first
          if (data_byte_i[7]) err = ERR_BAD_VALUE;
          else nxt.tag_left = tag_shifted;
        end
        if (err == ERR_NONE) begin
          if (cur.pos >= POS_HDR_LAST) begin
            nxt.pos   = 4'd0;
            nxt.stage = (nxt.tag_left == '0) ? STAGE_PAST : STAGE_FRM_HDR;
          end else begin
            nxt.pos = cur.pos + 4'd1;
          end
        end
      end

      // ten-byte frame header
      STAGE_FRM_HDR: begin
        nxt.tag_left = tag_dec;
        if (cur.pos <= POS_ID_LAST) begin
          if (!is_id_char(data_byte_i)) begin
            nxt.stage = STAGE_PAST;
          end else begin
            nxt.id_shift = {cur.id_shift[23:0], data_byte_i};
            nxt.pos      = cur.pos + 4'd1;
          end
        end else if (cur.pos <= POS_SIZE_LAST) begin
          nxt.size_val = {cur.size_val[23:0], data_byte_i};
          nxt.pos      = cur.pos + 4'd1;
        end else if (cur.pos == POS_FLAG0) begin
          nxt.pos = POS_HDR_LAST;
        end else begin
          nxt.kind       = kind_of(cur.id_shift);
          nxt.frame_left = cur.size_val;
          res.kind       = nxt.kind;
          res.length     = cur.size_val;
          nxt.pos        = 4'd0;
          if (cur.size_val == 32'd0) res.last = 1'b1;
          else nxt.stage = STAGE_PAYLOAD;
          if (tag_dec == '0) res.last = 1'b1;
        end
        if (tag_dec == '0) nxt.stage = STAGE_PAST;
      end

      // frame payload bytes
      STAGE_PAYLOAD: begin
        res.kind   = cur.kind;
        res.length = cur.size_val;
        if ((cur.kind != KIND_OTHER) || emit_unknown_i) begin
          res.valid   = 1'b1;
          res.payload = data_byte_i;
        end
        nxt.frame_left = frame_dec;
        nxt.tag_left   = tag_dec;
        if (frame_dec == 32'd0) begin
          res.last  = 1'b1;
          nxt.stage = STAGE_FRM_HDR;
          nxt.pos   = 4'd0;
        end
        if (tag_dec == '0) begin
          res.last  = 1'b1;
          nxt.stage = STAGE_PAST;
        end
      end

      // stopped on error until the next file
      STAGE_ERROR: begin
        nxt.stage = STAGE_ERROR;
      end

      default: begin
        nxt.stage = STAGE_PAST;
      end
    endcase

    if (err != ERR_NONE) begin
      nxt.err   = err;
      nxt.stage = STAGE_ERROR;
    end

    res.stage = nxt.stage;
    res.err   = nxt.err;
    res.done  = (nxt.stage == STAGE_PAST);

    state_o  = nxt;
    result_o = res;
  end

endmodule

`default_nettype wire

[bench/tb_top.sv]
// Testbench for id3v23_tag_frame_parser: a stimulus table, then generated ID3 files,
// each byte's result checked against a parse-walk predictor kept in this module.
// Depends on id3p_pkg and the RTL of the parser; reads and writes nothing.
module tb_top;
  import id3p_pkg::*;

  localparam int unsigned DIR_ROWS     = 26;
  localparam int unsigned PHASE_ITEMS  = 230;
  localparam int unsigned QUIET_LIMIT  = 4000;
  localparam logic [23:0] TAG_MARK     = 24'h49_44_33;
  localparam logic [7:0]  FLAG_BAD     = 8'h7F;

  // one row of the directed table; stg and err only mean something when typed is set
  typedef struct packed {
    logic       typed;
    stage_e     stg;
    err_e       err;
    logic       fs;
    logic [7:0] b;
  } dir_row_t;

  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    // no marker, then a byte that the stopped parser ignores
    '{1'b1, STAGE_ERROR,   ERR_NO_MARKER, 1'b1, 8'h00},
    '{1'b1, STAGE_ERROR,   ERR_NO_MARKER, 1'b0, 8'hFF},
    // tag header, unsync flag set, tag size 13
    '{1'b0, STAGE_TAG_HDR, ERR_NONE,      1'b1, 8'h49},
    '{1'b0, STAGE_TAG_HDR, ERR_NONE,      1'b0, 8'h44},
    '{1'b0, STAGE_TAG_HDR, ERR_NONE,      1'b0, 8'h33},
    '{1'b0, STAGE_TAG_HDR, ERR_NONE,      1'b0, 8'h03},
    '{1'b0, STAGE_TAG_HDR, ERR_NONE,      1'b0, 8'h00},
    '{1'b0, STAGE_TAG_HDR, ERR_NONE,      1'b0, 8'h80},
    '{1'b0, STAGE_TAG_HDR, ERR_NONE,      1'b0, 8'h00},
    '{1'b0, STAGE_TAG_HDR, ERR_NONE,      1'b0, 8'h00},
    '{1'b0, STAGE_TAG_HDR, ERR_NONE,      1'b0, 8'h00},
    '{1'b1, STAGE_FRM_HDR, ERR_NONE,      1'b0, 8'h0D},
    // TIT2 frame of size zero
    '{1'b0, STAGE_TAG_HDR, ERR_NONE,      1'b0, 8'h54},
    '{1'b0, STAGE_TAG_HDR, ERR_NONE,      1'b0, 8'h49},
    '{1'b0, STAGE_TAG_HDR, ERR_NONE,      1'b0, 8'h54},
    '{1'b0, STAGE_TAG_HDR, ERR_NONE,      1'b0, 8'h32},
    '{1'b0, STAGE_TAG_HDR, ERR_NONE,      1'b0, 8'h00},
    '{1'b0, STAGE_TAG_HDR, ERR_NONE,      1'b0, 8'h00},
    '{1'b0, STAGE_TAG_HDR, ERR_NONE,      1'b0, 8'h00},
    '{1'b0, STAGE_TAG_HDR, ERR_NONE,      1'b0, 8'h00},
    '{1'b0, STAGE_TAG_HDR, ERR_NONE,      1'b0, 8'h00},
    '{1'b1, STAGE_FRM_HDR, ERR_NONE,      1'b0, 8'h00},
    // tag runs out inside the next frame ID, then a byte past the tag
    '{1'b0, STAGE_TAG_HDR, ERR_NONE,      1'b0, 8'h41},
    '{1'b0, STAGE_TAG_HDR, ERR_NONE,      1'b0, 8'h50},
    '{1'b1, STAGE_PAST,    ERR_NONE,      1'b0, 8'h49},
    '{1'b1, STAGE_PAST,    ERR_NONE,      1'b0, 8'hFF}
  };

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic        cfg_wdata_i   = 1'b0;
  logic        in_valid_i    = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i   = 8'h00;
  logic        file_start_i  = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i   = 1'b0;
  logic [2:0]  stage_o;
  logic [1:0]  error_code_o;
  logic [2:0]  frame_kind_o;
  logic [31:0] frame_length_o;
  logic [7:0]  payload_byte_o;
  logic        payload_valid_o;
  logic        frame_last_o;
  logic        tag_done_o;

  id3v23_tag_frame_parser uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .data_byte_i     (data_byte_i),
    .file_start_i    (file_start_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .stage_o         (stage_o),
    .error_code_o    (error_code_o),
    .frame_kind_o    (frame_kind_o),
    .frame_length_o  (frame_length_o),
    .payload_byte_o  (payload_byte_o),
    .payload_valid_o (payload_valid_o),
    .frame_last_o    (frame_last_o),
    .tag_done_o      (tag_done_o)
  );

  // predictor copy of the parse walk and the one register
  stage_e      walk_stage;
  logic [3:0]  walk_pos;
  logic [27:0] tag_left;
  logic [31:0] id_sr;
  logic [31:0] size_sr;
  logic [31:0] frame_left;
  kind_e       frame_kind;
  err_e        err_latch;
  logic        emit_unknown;

  result_t     pending_results [$];
  logic [8:0]  stim_q [$];
  logic        src_burst = 1'b0;

  int unsigned bytes_fed       = 0;
  int unsigned random_items    = 0;
  int unsigned files_built     = 0;
  int unsigned results_checked = 0;
  int unsigned payload_beats   = 0;
  int unsigned tag_end_beats   = 0;
  int unsigned error_beats     = 0;
  int unsigned mismatches      = 0;
  int unsigned quiet_cycles    = 0;
  int unsigned sink_hold       = 0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // letters of either case and digits
  function automatic logic id_char_ok(input logic [7:0] c);
    logic [7:0] folded;
    folded = c | 8'h20;
    return ((c >= 8'h30) && (c <= 8'h39)) || ((folded >= 8'h61) && (folded <= 8'h7A));
  endfunction

  function automatic logic [31:0] known_id(input int unsigned k);
    logic [31:0] id;
    case (k)
      0:       id = ID_COMM;
      1:       id = ID_TALB;
      2:       id = ID_TPE1;
      3:       id = ID_TIT2;
      4:       id = ID_TRCK;
      5:       id = ID_TYER;
      default: id = ID_APIC;
    endcase
    return id;
  endfunction

  // kind codes follow the order of known_id, starting at one
  function automatic kind_e classify_id(input logic [31:0] id);
    kind_e k;
    k = KIND_OTHER;
    for (int unsigned i = 0; i < 7; i++)
      if (id == known_id(i)) k = kind_e'(i + 1);
    return k;
  endfunction

  task automatic clear_walk();
    walk_stage = STAGE_TAG_HDR;
    walk_pos   = '0;
    tag_left   = '0;
    id_sr      = '0;
    size_sr    = '0;
    frame_left = '0;
    frame_kind = KIND_OTHER;
    err_latch  = ERR_NONE;
  endtask

  // advance the walk by one file byte and form the result it causes
  task automatic walk_byte(input logic [7:0] b, input logic fs, output result_t r);
    err_e e;
    e = ERR_NONE;
    r = '0;
    if (fs) clear_walk();
    case (walk_stage)
      STAGE_TAG_HDR: begin
        if (walk_pos <= 4'd2) begin
          if (b != TAG_MARK[8 * (2 - walk_pos) +: 8]) e = ERR_NO_MARKER;
        end else if (walk_pos == 4'd3) begin
          if (b != 8'h03) e = ERR_BAD_VALUE;
        end else if (walk_pos == 4'd4) begin
          if (b != 8'h00) e = ERR_BAD_VALUE;
        end else if (walk_pos == 4'd5) begin
          if ((b & FLAG_BAD) != 8'h00) e = ERR_FLAGS;
        end else if (b[7]) begin
          e = ERR_BAD_VALUE;
        end else begin
          tag_left = {tag_left[20:0], b[6:0]};
        end
        if (e == ERR_NONE) begin
          if (walk_pos >= 4'd9) begin
            walk_pos   = '0;
            walk_stage = (tag_left == 0) ? STAGE_PAST : STAGE_FRM_HDR;
          end else begin
            walk_pos = walk_pos + 4'd1;
          end
        end
      end
      STAGE_FRM_HDR: begin
        tag_left = tag_left - 28'd1;
        if (walk_pos <= 4'd3) begin
          // a non-ID character means padding
          if (!id_char_ok(b)) begin
            walk_stage = STAGE_PAST;
          end else begin
            id_sr    = {id_sr[23:0], b};
            walk_pos = walk_pos + 4'd1;
          end
        end else if (walk_pos <= 4'd7) begin
          size_sr  = {size_sr[23:0], b};
          walk_pos = walk_pos + 4'd1;
        end else if (walk_pos == 4'd8) begin
          walk_pos = 4'd9;
        end else begin
          frame_kind = classify_id(id_sr);
          frame_left = size_sr;
          r.kind     = frame_kind;
          r.length   = size_sr;
          walk_pos   = '0;
          if (frame_left == 0) r.last = 1'b1;
          else walk_stage = STAGE_PAYLOAD;
          if (tag_left == 0) r.last = 1'b1;
        end
        if (tag_left == 0) walk_stage = STAGE_PAST;
      end
      STAGE_PAYLOAD: begin
        r.kind   = frame_kind;
        r.length = size_sr;
        if ((frame_kind != KIND_OTHER) || emit_unknown) begin
          r.valid   = 1'b1;
          r.payload = b;
        end
        frame_left = frame_left - 32'd1;
        tag_left   = tag_left - 28'd1;
        if (frame_left == 0) begin
          r.last     = 1'b1;
          walk_stage = STAGE_FRM_HDR;
          walk_pos   = '0;
        end
        if (tag_left == 0) begin
          r.last     = 1'b1;
          walk_stage = STAGE_PAST;
        end
      end
      STAGE_ERROR: ;
      default: walk_stage = STAGE_PAST;
    endcase
    if (e != ERR_NONE) begin
      err_latch  = e;
      walk_stage = STAGE_ERROR;
    end
    r.stage = walk_stage;
    r.err   = err_latch;
    r.done  = (walk_stage == STAGE_PAST);
  endtask

  function automatic int unsigned pick_gap();
    int unsigned v;
    v = $urandom_range(0, 99);
    if (v < 60) return 0;
    if (v < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] rand_id_char();
    int unsigned v;
    v = $urandom_range(0, 61);
    if (v < 10) return 8'(8'h30 + v);
    if (v < 36) return 8'(8'h41 + v - 10);
    return 8'(8'h61 + v - 36);
  endfunction

  // mostly zero bytes, otherwise any byte that cannot start a frame ID
  function automatic logic [7:0] pad_byte();
    logic [7:0] v;
    if ($urandom_range(0, 3) != 0) return 8'h00;
    do v = 8'($urandom); while (id_char_ok(v));
    return v;
  endfunction

  // one generated file: mostly well-formed tags with random frames, some noise,
  // corrupted headers and files cut short by the next file start
  task automatic build_file();
    logic [7:0]  body [$];
    logic [7:0]  hdr [10];
    logic [31:0] id;
    logic [31:0] fsize;
    logic [27:0] tsize;
    logic        pad;
    int unsigned mode, nfr, pick, npay, keep, i, j;
    mode = $urandom_range(0, 99);
    files_built++;
    if (mode < 6) begin
      npay = $urandom_range(1, 12);
      for (i = 0; i < npay; i++)
        stim_q.push_back({(i == 0) || ($urandom_range(0, 7) == 0), 8'($urandom)});
      return;
    end
    // frames
    nfr = $urandom_range(0, 4);
    for (i = 0; i < nfr; i++) begin
      pick = $urandom_range(0, 11);
      id = known_id(pick);
      for (j = 0; j < 4; j++) begin
        if (pick < 7) body.push_back(id[31 - 8 * j -: 8]);
        else if (pick < 11) body.push_back(rand_id_char());
        else body.push_back(8'($urandom));
      end
      pick = $urandom_range(0, 19);
      if (pick < 3) fsize = 0;
      else if (pick < 16) fsize = $urandom_range(1, 8);
      else if (pick < 19) fsize = $urandom_range(9, 40);
      else fsize = $urandom_range(0, 1) ? 32'hFFFF_FFFF : $urandom;
      for (j = 0; j < 4; j++) body.push_back(fsize[31 - 8 * j -: 8]);
      body.push_back(8'($urandom));
      body.push_back(8'($urandom));
      npay = (fsize > 40) ? $urandom_range(0, 8) : fsize;
      for (j = 0; j < npay; j++) body.push_back(8'($urandom));
    end
    // tag size: exact, longer with padding, cut short, zero or huge
    pick = $urandom_range(0, 99);
    pad  = 1'b0;
    if (pick < 40) begin
      tsize = 28'(body.size());
    end else if (pick < 65) begin
      tsize = 28'(body.size() + $urandom_range(1, 300));
      pad   = 1'b1;
    end else if (pick < 85) begin
      tsize = (body.size() == 0) ? '0 : 28'($urandom_range(1, body.size()));
      keep  = tsize + $urandom_range(0, 2);
      while (body.size() > keep) void'(body.pop_back());
    end else if (pick < 92) begin
      tsize = '0;
      keep  = $urandom_range(0, 3);
      while (body.size() > keep) void'(body.pop_back());
    end else begin
      tsize = (pick == 99) ? 28'h0FF_FFFF | 28'hF00_0000
                           : 28'($urandom_range(0, 28'h0FFF_FFFF));
      pad   = 1'b1;
    end
    hdr = '{8'h49, 8'h44, 8'h33, 8'h03, 8'h00, {$urandom_range(0, 1) == 1, 7'd0},
            {1'b0, tsize[27:21]}, {1'b0, tsize[20:14]}, {1'b0, tsize[13:7]},
            {1'b0, tsize[6:0]}};
    if (mode < 22) hdr[$urandom_range(0, 9)] = 8'($urandom);
    if ((mode >= 22) && (mode < 30)) begin
      keep = $urandom_range(0, body.size());
      while (body.size() > keep) void'(body.pop_back());
      pad = 1'b0;
    end
    for (j = 0; j < 10; j++) stim_q.push_back({j == 0, hdr[j]});
    foreach (body[k]) stim_q.push_back({1'b0, body[k]});
    if (pad) begin
      stim_q.push_back({1'b0, pad_byte()});
      npay = $urandom_range(0, 3);
      for (j = 0; j < npay; j++) stim_q.push_back({1'b0, 8'($urandom)});
    end
  endtask

  // present one byte, hold it until accepted, then queue its expected result
  task automatic feed(input logic [7:0] b, input logic fs, input logic typed,
                      input stage_e tstg, input err_e terr);
    result_t     want;
    int unsigned gap;
    gap = src_burst ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    data_byte_i  <= b;
    file_start_i <= fs;
    in_valid_i   <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    walk_byte(b, fs, want);
    if (typed) begin
      want.stage = tstg;
      want.err   = terr;
      want.done  = (tstg == STAGE_PAST);
    end
    pending_results.push_back(want);
    bytes_fed++;
  endtask

  // register write once every outstanding result is back
  task automatic write_emit(input logic v);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    cfg_wdata_i <= v;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    emit_unknown = v;
  endtask

  task automatic check_field(input string fname, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, got %0h", fname, want, got);
      mismatches++;
    end
  endtask

  // receiver pacing: long ready stretches, short stalls and a few long ones
  always @(posedge clk_i) begin : sink_pacing
    int unsigned v;
    if (sink_hold != 0) begin
      sink_hold <= sink_hold - 1;
    end else begin
      v = $urandom_range(0, 99);
      if (v < 70) begin
        out_ready_i <= 1'b1;
        sink_hold   <= $urandom_range(0, 20);
      end else if (v < 95) begin
        out_ready_i <= 1'b0;
        sink_hold   <= $urandom_range(0, 3);
      end else begin
        out_ready_i <= 1'b0;
        sink_hold   <= $urandom_range(8, 35);
      end
    end
  end

  // compare each result beat with the oldest expectation
  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected: stage %0d", stage_o);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("stage", 32'(want.stage), 32'(stage_o));
        check_field("error_code", 32'(want.err), 32'(error_code_o));
        check_field("frame_kind", 32'(want.kind), 32'(frame_kind_o));
        check_field("frame_length", want.length, frame_length_o);
        check_field("payload_byte", 32'(want.payload), 32'(payload_byte_o));
        check_field("payload_valid", 32'(want.valid), 32'(payload_valid_o));
        check_field("frame_last", 32'(want.last), 32'(frame_last_o));
        check_field("tag_done", 32'(want.done), 32'(tag_done_o));
        results_checked++;
        if (want.valid) payload_beats++;
        if (want.done) tag_end_beats++;
        if (want.stage == STAGE_ERROR) error_beats++;
      end
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("[id3v23_tag_frame_parser] ERROR");
    $finish;
  end

  // reset, directed table, then four phases of generated files
  initial begin : stimulus
    int unsigned i, p;
    logic [8:0]  item;
    clear_walk();
    emit_unknown = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_emit(1'b0);
    for (i = 0; i < DIR_ROWS; i++)
      feed(DIRECTED[i].b, DIRECTED[i].fs, DIRECTED[i].typed, DIRECTED[i].stg,
           DIRECTED[i].err);
    for (p = 0; p < 4; p++) begin
      write_emit(~p[0]);
      while (random_items < (p + 1) * PHASE_ITEMS) begin
        build_file();
        src_burst = ($urandom_range(0, 3) == 0);
        while (stim_q.size() != 0) begin
          item = stim_q.pop_front();
          feed(item[7:0], item[8], 1'b0, STAGE_TAG_HDR, ERR_NONE);
          random_items++;
        end
      end
    end
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    $display("fed %0d bytes (%0d from the table) in %0d generated files,",
             bytes_fed, DIR_ROWS, files_built);
    $display("  unknown payload off and on");
    $display("checked %0d results: %0d payload out, %0d past tag, %0d stopped on error;",
             results_checked, payload_beats, tag_end_beats, error_beats);
    $display("  %0d mismatches", mismatches);
    if (mismatches == 0) $display("[id3v23_tag_frame_parser] OK");
    else $display("[id3v23_tag_frame_parser] ERROR");
    $finish;
  end

endmodule
